>>> rtl/mrdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrdd_pkg;

    // Default number of table entries.
    localparam int MAX_REGIONS_DEF = 16;

    localparam int ADDR_W = 48;
    localparam int TAG_W  = 8;
    localparam int CNT_W  = 5;

    // The limit register comes out of reset allowing sixteen regions.
    localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [0:0] {
        REQ_REGISTER = 1'b0,
        REQ_ACCESS   = 1'b1
    } req_kind_t;

    typedef enum logic [2:0] {
        OUT_REGISTERED = 3'd0,
        OUT_FULL       = 3'd1,
        OUT_ABORT      = 3'd2,
        OUT_FORWARD    = 3'd3,
        OUT_IGNORED    = 3'd4,
        OUT_EMU_WRITE  = 3'd5,
        OUT_EMU_READ   = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        req_kind_t         req_type;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] region_size;
        logic [TAG_W-1:0]  handler_tag;
        logic              syndrome_valid;
        logic              cache_maint;
        logic              is_write;
    } req_t;

    typedef struct packed {
        outcome_t          outcome;
        logic [TAG_W-1:0]  matched_tag;
        logic [CNT_W-1:0]  region_total;
    } rsp_t;

    // One region as it sits in the table memory.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/mrdd_table.sv
`timescale 1ns / 1ps
`default_nettype none

module mrdd_table #(
    parameter int MAX_REGIONS = mrdd_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                                           clk,
    input  wire logic                                           wr_en,
    input  wire logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1)-1:0] wr_idx,
    input  wire mrdd_pkg::entry_t                               wr_data,
    input  wire logic                                           rd_en,
    input  wire logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1)-1:0] rd_idx,
    output mrdd_pkg::entry_t                                    rd_data
);
    import mrdd_pkg::*;

    entry_t mem [MAX_REGIONS];
    entry_t rd_data_reg;

    // Single write port, single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/mrdd_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module mrdd_cmp (
    input  wire logic [mrdd_pkg::ADDR_W-1:0] addr,
    input  wire logic [mrdd_pkg::ADDR_W-1:0] base,
    input  wire logic [mrdd_pkg::ADDR_W-1:0] size,
    input  wire logic [mrdd_pkg::ADDR_W-1:0] best_base,
    input  wire logic                        hit,
    output logic                             take
);
    import mrdd_pkg::*;

    logic [ADDR_W:0] diff;
    logic            covered;
    logic            lower;

    // The borrow out of the subtraction tells whether the address is below
    // the base; the end of the region is never formed, so it cannot wrap.
    assign diff    = {1'b0, addr} - {1'b0, base};
    assign covered = !diff[ADDR_W] && (diff[ADDR_W-1:0] < size);
    assign lower   = base < best_base;

    // Strictly lower base replaces the current best, so the earlier entry
    // wins among equal bases.
    assign take = covered && (!hit || lower);

endmodule

`default_nettype wire

>>> rtl/mrdd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mrdd_ctrl #(
    parameter int MAX_REGIONS = mrdd_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           req_valid,
    output logic                                                req_stall,
    input  wire mrdd_pkg::req_t                                 req,
    output logic                                                rsp_valid,
    input  wire logic                                           rsp_stall,
    output mrdd_pkg::rsp_t                                      rsp,
    input  wire logic [mrdd_pkg::CNT_W-1:0]                     limit,
    output logic                                                tbl_wr_en,
    output logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1)-1:0] tbl_wr_idx,
    output mrdd_pkg::entry_t                                    tbl_wr_data,
    output logic                                                tbl_rd_en,
    output logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1)-1:0] tbl_rd_idx,
    input  wire mrdd_pkg::entry_t                               tbl_rd_data,
    output logic [mrdd_pkg::ADDR_W-1:0]                         cmp_addr,
    output logic [mrdd_pkg::ADDR_W-1:0]                         cmp_best_base,
    output logic                                                cmp_hit,
    input  wire logic                                           cmp_take
);
    import mrdd_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              last_reg, last_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] best_base_reg, best_base_next;
    logic [TAG_W-1:0]  best_tag_reg, best_tag_next;
    rsp_t              res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic accept;
    logic out_free;
    logic room;
    logic decodable;
    logic any_hit;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign room      = (count_reg < limit) && (int'(count_reg) < MAX_REGIONS);
    assign decodable = item_reg.syndrome_valid || item_reg.cache_maint;
    assign any_hit   = hit_reg || cmp_take;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cmp_addr      = item_reg.address;
    assign cmp_best_base = best_base_reg;
    assign cmp_hit       = hit_reg;

    assign tbl_wr_idx  = IW'(count_reg);
    assign tbl_wr_data = '{base: item_reg.address, size: item_reg.region_size,
                           tag: item_reg.handler_tag};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((item_reg.req_type == REQ_ACCESS) && decodable && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        last_next      = last_reg;
        hit_next       = hit_reg;
        best_base_next = best_base_reg;
        best_tag_next  = best_tag_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        tbl_wr_en      = 1'b0;
        tbl_rd_en      = 1'b0;
        tbl_rd_idx     = IW'(scan_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = req;
                end
            end
            ST_EXEC:
            begin
                hit_next             = 1'b0;
                res_next.matched_tag = '0;
                res_next.region_total = count_reg;
                if (item_reg.req_type == REQ_REGISTER)
                begin
                    if (room)
                    begin
                        tbl_wr_en             = 1'b1;
                        count_next            = count_reg + 1'b1;
                        res_next.outcome      = OUT_REGISTERED;
                        res_next.region_total = count_reg + 1'b1;
                    end
                    else
                    begin
                        res_next.outcome = OUT_FULL;
                    end
                end
                else if (!decodable)
                begin
                    res_next.outcome = OUT_ABORT;
                end
                else if (count_reg == '0)
                begin
                    res_next.outcome = OUT_FORWARD;
                end
                else
                begin
                    // Start the walk at entry zero.
                    tbl_rd_en  = 1'b1;
                    tbl_rd_idx = '0;
                    scan_next  = CNT_W'(1);
                    last_next  = (count_reg == CNT_W'(1));
                end
            end
            ST_SCAN:
            begin
                // Read data holds the entry issued in the previous cycle.
                if (cmp_take)
                begin
                    hit_next       = 1'b1;
                    best_base_next = tbl_rd_data.base;
                    best_tag_next  = tbl_rd_data.tag;
                end
                if (last_reg)
                begin
                    res_next.matched_tag = '0;
                    if (!any_hit)
                    begin
                        res_next.outcome = OUT_FORWARD;
                    end
                    else if (item_reg.cache_maint)
                    begin
                        res_next.outcome = OUT_IGNORED;
                    end
                    else
                    begin
                        res_next.outcome     = item_reg.is_write ? OUT_EMU_WRITE
                                                                 : OUT_EMU_READ;
                        res_next.matched_tag = cmp_take ? tbl_rd_data.tag : best_tag_reg;
                    end
                end
                else
                begin
                    tbl_rd_en  = 1'b1;
                    tbl_rd_idx = IW'(scan_reg);
                    scan_next  = scan_reg + 1'b1;
                    last_next  = (CNT_W'(scan_reg + 1'b1) == count_reg);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        scan_reg      <= scan_next;
        last_reg      <= last_next;
        hit_reg       <= hit_next;
        best_base_reg <= best_base_next;
        best_tag_reg  <= best_tag_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_REGIONS)
        else $error("region count exceeds table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == ST_EXEC) && (count_reg == $past(count_reg) + 1'b1))
        else $error("region count changed outside a registration");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented without a finished item");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg <= count_reg) && (count_reg != '0))
        else $error("table walk beyond registered regions");

    a_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |-> (state_reg == ST_EXEC) && (item_reg.req_type == REQ_REGISTER))
        else $error("table written by an access item");
`endif

endmodule

`default_nettype wire

>>> rtl/mmio_region_decode_dispatch_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                       Direction  Contents
// req       req_valid, req_stall, req     in         one register or access request
// rsp       rsp_valid, rsp_stall, rsp     out        outcome, matched tag, region total
// cfg       cfg_we, cfg_data              in         region limit register, write only
//
// A register request or a request that decodes without a walk passes through
// the execute and done states; its result enters the output register as the
// block returns to idle, where the next item can be accepted. A lookup walks
// the region table one entry per cycle through the single read port and one
// shared comparator in the scan state before it reaches the done state.
// Reset clears the region count and sets the limit to 16; table contents stay
// undefined, but only entries below the count are ever read.
// The block takes one item at a time; a stall on rsp holds the result in the
// output register, and the next item finishes its work and then waits in its
// last state until that register is free.

module mmio_region_decode_dispatch_top #(
    parameter int MAX_REGIONS = mrdd_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire mrdd_pkg::req_t             req,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output mrdd_pkg::rsp_t                  rsp,
    input  wire logic                       cfg_we,
    input  wire logic [mrdd_pkg::CNT_W-1:0] cfg_data
);
    import mrdd_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    // The limit register must only be written by the user while the block is idle,
    // so the sequencer can read it directly; the block itself does not enforce it.
    logic [CNT_W-1:0]  limit_reg;

    logic              tbl_wr_en;
    logic [IW-1:0]     tbl_wr_idx;
    entry_t            tbl_wr_data;
    logic              tbl_rd_en;
    logic [IW-1:0]     tbl_rd_idx;
    entry_t            tbl_rd_data;

    logic [ADDR_W-1:0] cmp_addr;
    logic [ADDR_W-1:0] cmp_best_base;
    logic              cmp_hit;
    logic              cmp_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Sequencer: owns the item, the region count and the output register.
    mrdd_ctrl #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .limit         (limit_reg),
        .tbl_wr_en     (tbl_wr_en),
        .tbl_wr_idx    (tbl_wr_idx),
        .tbl_wr_data   (tbl_wr_data),
        .tbl_rd_en     (tbl_rd_en),
        .tbl_rd_idx    (tbl_rd_idx),
        .tbl_rd_data   (tbl_rd_data),
        .cmp_addr      (cmp_addr),
        .cmp_best_base (cmp_best_base),
        .cmp_hit       (cmp_hit),
        .cmp_take      (cmp_take)
    );

    // Region table: base, size and tag in one word per entry.
    mrdd_table #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_idx  (tbl_wr_idx),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_idx  (tbl_rd_idx),
        .rd_data (tbl_rd_data)
    );

    // Shared range comparator, used once per table entry during a walk.
    mrdd_cmp u_cmp (
        .addr      (cmp_addr),
        .base      (tbl_rd_data.base),
        .size      (tbl_rd_data.size),
        .best_base (cmp_best_base),
        .hit       (cmp_hit),
        .take      (cmp_take)
    );

endmodule

`default_nettype wire
